/* rtl/bounded_queue_remove_by_key_defines.svh */
// Assertion macros for the keyed-delete queue
`ifndef BOUNDED_QUEUE_REMOVE_BY_KEY_DEFINES_SVH
`define BOUNDED_QUEUE_REMOVE_BY_KEY_DEFINES_SVH

// same-cycle implication
`define BQRK_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BQRK_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/bqrk_pkg.sv */
// Package: widths, codes and control structs of the keyed-delete queue
`timescale 1ns / 1ps

package bqrk_pkg;

  localparam int DEPTH_DEF    = 16;
  localparam int KEY_BITS_DEF = 16;

  localparam int CMD_W   = 2;
  localparam int KEY_W   = 16;
  localparam int CAP_W   = 5;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic [CMD_W-1:0] CMD_ENQ = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REM = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QRY = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd2;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd3;

  typedef struct packed {
    logic capture;
    logic exec;
    logic scan;
    logic load_out;
  } bqrk_cmd_t;

  typedef struct packed {
    logic need_scan;
    logic scan_last;
  } bqrk_sts_t;

endpackage

/* rtl/bounded_queue_remove_by_key.sv */
// Top level: bounded ordered key queue with remove-by-key
`timescale 1ns / 1ps
// Usage:
//   in_*  : one item per handshake; in_tuser carries the command (enqueue,
//           remove, query), in_tdata the key. Only the low KEY_BITS key bits
//           are stored and compared.
//   out_* : one result per item, in order: status, count and empty flag.
//   cfg_* : capacity register, always ready; written by the user only while
//           the block is idle, a rule the block itself leaves unenforced.
// Flow: enqueue, query and remove on an empty queue go from capture
//   through the exec and finish states to out_tvalid. A remove on a
//   non-empty queue also scans: the store has one registered read port, so
//   the scan and compaction read one entry per cycle, writing each entry
//   behind the hit one slot lower. The block takes one item at a time.
// Reset: occupancy clears, capacity returns to 16; stored keys are not
//   cleared and need no clearing pass.
// Stall: the result register holds while out_tready is low; the next item
//   is still accepted and waits for the register before its result loads.

module bounded_queue_remove_by_key #(
  parameter int DEPTH    = bqrk_pkg::DEPTH_DEF,
  parameter int KEY_BITS = bqrk_pkg::KEY_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] key
  input  logic [1:0]  in_tuser,   // [1:0] command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [1:0] status, [6:2] count, [7] empty_res
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data    // [4:0] capacity
);

  bqrk_pkg::bqrk_cmd_t                 cmd;
  bqrk_pkg::bqrk_sts_t                 sts;
  logic [bqrk_pkg::STAT_W-1:0]         out_status;
  logic [bqrk_pkg::COUNT_W-1:0]        out_count;
  logic                                out_empty;

  assign cfg_ready = 1'b1;

  bqrk_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  bqrk_dp #(
    .DEPTH    (DEPTH),
    .KEY_BITS (KEY_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_command (in_tuser),
    .in_key     (in_tdata),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_cap    (cfg_data),
    .out_status (out_status),
    .out_count  (out_count),
    .out_empty  (out_empty)
  );

  assign out_tdata = {out_empty, out_count, out_status};

endmodule

/* rtl/bqrk_dp.sv */
// Datapath: key store, occupancy, scan-and-compact pipeline and result register
`timescale 1ns / 1ps
`include "bounded_queue_remove_by_key_defines.svh"

module bqrk_dp #(
  parameter int DEPTH    = bqrk_pkg::DEPTH_DEF,
  parameter int KEY_BITS = bqrk_pkg::KEY_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  bqrk_pkg::bqrk_cmd_t           cmd,
  output bqrk_pkg::bqrk_sts_t           sts,
  input  logic [bqrk_pkg::CMD_W-1:0]    in_command,
  input  logic [bqrk_pkg::KEY_W-1:0]    in_key,
  input  logic                          cfg_we,
  input  logic [bqrk_pkg::CAP_W-1:0]    cfg_cap,
  output logic [bqrk_pkg::STAT_W-1:0]   out_status,
  output logic [bqrk_pkg::COUNT_W-1:0]  out_count,
  output logic                          out_empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int OW = $clog2(DEPTH + 1);
  localparam int CW = (OW > bqrk_pkg::CAP_W) ? OW : bqrk_pkg::CAP_W;

  logic [KEY_BITS-1:0]             mem [DEPTH];
  logic [KEY_BITS-1:0]             rdata_r;
  logic [KEY_BITS-1:0]             key_r;
  logic [bqrk_pkg::CMD_W-1:0]      cmd_r;
  logic [bqrk_pkg::CAP_W-1:0]      cap_r, cap_nxt;
  logic [OW-1:0]                   occ_r, occ_nxt;
  logic [OW-1:0]                   nxt_r, nxt_nxt;
  logic [AW-1:0]                   rd_idx_r, rd_idx_nxt;
  logic                            rd_vld_r, rd_vld_nxt;
  logic                            found_r, found_nxt;
  logic [bqrk_pkg::STAT_W-1:0]     stat_r, stat_nxt;
  logic [bqrk_pkg::STAT_W-1:0]     out_status_r;
  logic [bqrk_pkg::COUNT_W-1:0]    out_count_r;
  logic                            out_empty_r;

  logic                            full;
  logic                            match;
  logic                            re, we;
  logic [AW-1:0]                   ra, wa;
  logic [KEY_BITS-1:0]             wd;

  assign full  = (CW'(occ_r) >= CW'(cap_r)) || (occ_r == OW'(DEPTH));
  assign match = (rdata_r == key_r);

  assign sts.need_scan = (cmd_r == bqrk_pkg::CMD_REM) && (occ_r != '0);
  assign sts.scan_last = cmd.scan && rd_vld_r && (OW'(rd_idx_r) == occ_r - OW'(1));

  always_comb begin
    re      = 1'b0;
    ra      = '0;
    nxt_nxt = nxt_r;
    if (cmd.exec && sts.need_scan) begin
      re      = 1'b1;
      nxt_nxt = OW'(1);
    end else if (cmd.scan && (nxt_r < occ_r)) begin
      re      = 1'b1;
      ra      = nxt_r[AW-1:0];
      nxt_nxt = nxt_r + OW'(1);
    end
    rd_vld_nxt = re;
    rd_idx_nxt = re ? ra : rd_idx_r;
  end

  always_comb begin
    we = 1'b0;
    wa = '0;
    wd = key_r;
    if (cmd.exec && (cmd_r == bqrk_pkg::CMD_ENQ) && !full) begin
      we = 1'b1;
      wa = occ_r[AW-1:0];
    end else if (cmd.scan && rd_vld_r && found_r) begin
      we = 1'b1;
      wa = rd_idx_r - AW'(1);
      wd = rdata_r;
    end
  end

  always_comb begin
    occ_nxt   = occ_r;
    stat_nxt  = stat_r;
    found_nxt = found_r;
    cap_nxt   = cfg_we ? cfg_cap : cap_r;
    if (cmd.exec) begin
      found_nxt = 1'b0;
      case (cmd_r)
        bqrk_pkg::CMD_ENQ: begin
          if (full) begin
            stat_nxt = bqrk_pkg::ST_FULL;
          end else begin
            stat_nxt = bqrk_pkg::ST_OK;
            occ_nxt  = occ_r + OW'(1);
          end
        end
        bqrk_pkg::CMD_REM: begin
          stat_nxt = sts.need_scan ? bqrk_pkg::ST_NOTFOUND : bqrk_pkg::ST_EMPTY;
        end
        default: begin
          stat_nxt = bqrk_pkg::ST_OK;
        end
      endcase
    end else if (cmd.scan && rd_vld_r) begin
      found_nxt = found_r | match;
      if (sts.scan_last && found_nxt) begin
        stat_nxt = bqrk_pkg::ST_OK;
        occ_nxt  = occ_r - OW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rdata_r <= mem[ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r    <= '0;
      cap_r    <= bqrk_pkg::CAP_RESET;
      rd_vld_r <= 1'b0;
      found_r  <= 1'b0;
    end else begin
      occ_r    <= occ_nxt;
      cap_r    <= cap_nxt;
      rd_vld_r <= rd_vld_nxt;
      found_r  <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    nxt_r    <= nxt_nxt;
    rd_idx_r <= rd_idx_nxt;
    stat_r   <= stat_nxt;
    if (cmd.capture) begin
      cmd_r <= in_command;
      key_r <= KEY_BITS'(in_key);
    end
    if (cmd.load_out) begin
      out_status_r <= stat_r;
      out_count_r  <= bqrk_pkg::COUNT_W'(occ_r);
      out_empty_r  <= (occ_r == '0);
    end
  end

  assign out_status = out_status_r;
  assign out_count  = out_count_r;
  assign out_empty  = out_empty_r;

  `BQRK_ASSERT_NEXT(a_occ_hold, !cmd.exec && !sts.scan_last, occ_r == $past(occ_r), "occupancy moved outside an operation")
  `BQRK_ASSERT_NEXT(a_scan_seq, cmd.scan && rd_vld_r && !sts.scan_last && (nxt_r < occ_r), rd_vld_r && (rd_idx_r == $past(rd_idx_r) + AW'(1)), "scan read order broken")
  `BQRK_ASSERT_NEXT(a_full_hold, cmd.exec && (cmd_r == bqrk_pkg::CMD_ENQ) && full, occ_r == $past(occ_r), "enqueue taken while full")

endmodule

/* rtl/bqrk_ctrl.sv */
// Controller: item sequencing and result register handshake
`timescale 1ns / 1ps

module bqrk_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  input  bqrk_pkg::bqrk_sts_t  sts,
  output bqrk_pkg::bqrk_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_EXEC   = 4'b0010,
    S_SCAN   = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt    = state_r;
    cmd.capture  = 1'b0;
    cmd.exec     = 1'b0;
    cmd.scan     = 1'b0;
    cmd.load_out = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = sts.need_scan ? S_SCAN : S_FINISH;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_last) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule
